>>> rtl/periodic_task_scheduler_defines.svh
// Assertion helpers for the scheduler RTL.
`ifndef PERIODIC_TASK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define PTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while in reset.
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int TASK_ID_W     = 4;

    // action codes (s_tuser)
    localparam logic ACT_REGISTER = 1'b0;
    localparam logic ACT_PROCESS  = 1'b1;

    // status codes (m_tuser)
    localparam logic [STATUS_W-1:0] ST_REGISTERED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUE        = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE       = 2'd3;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              load;     // store period/now in the addressed cell
        logic              eval;     // compare elapsed time against period
        logic              advance;  // move the scan token one cell on
        logic              clear;    // drop the scan token
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] now;
    } cell_ctrl_t;

    // status of one cell back to the sequencer
    typedef struct packed {
        logic hit;   // token sits here and this slot is due
        logic last;  // no due slot further down the chain
    } cell_stat_t;

endpackage

`default_nettype wire

>>> rtl/pts_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pts_cell #(
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire pts_pkg::cell_ctrl_t ctrl,
    input  wire  [CNT_W-1:0]        count,
    input  wire                     tok_in,
    output logic                    tok_out,
    input  wire                     rest_in,
    output logic                    rest_out,
    output pts_pkg::cell_stat_t     stat
);

    logic [pts_pkg::TIME_W-1:0] period_reg;
    logic [pts_pkg::TIME_W-1:0] last_run_reg;
    logic [pts_pkg::TIME_W-1:0] elapsed;
    logic                       active;
    logic                       sel;
    logic                       is_due;
    logic                       due_reg;
    logic                       due_next;
    logic                       tok_reg;
    logic                       tok_next;

    assign active  = count > CNT_W'(INDEX);
    assign sel     = ctrl.load && (count == CNT_W'(INDEX));
    assign elapsed = ctrl.now - last_run_reg;
    assign is_due  = active && (elapsed >= period_reg);

    always_comb
    begin
        due_next = due_reg;
        tok_next = tok_reg;
        if (ctrl.eval)
        begin
            due_next = is_due;
        end
        if (ctrl.clear)
        begin
            tok_next = 1'b0;
        end
        else if (ctrl.advance)
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_reg <= 1'b0;
            tok_reg <= 1'b0;
        end
        else
        begin
            due_reg <= due_next;
            tok_reg <= tok_next;
        end
    end

    // Slot payload; a due slot restarts its period at the pass time.
    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            period_reg   <= ctrl.period;
            last_run_reg <= ctrl.now;
        end
        else if (ctrl.eval && is_due)
        begin
            last_run_reg <= ctrl.now;
        end
    end

    assign tok_out   = tok_reg;
    assign rest_out  = due_reg | rest_in;
    assign stat.hit  = tok_reg & due_reg;
    assign stat.last = !rest_in;

endmodule

`default_nettype wire

>>> rtl/periodic_task_scheduler.sv
// Periodic task scheduler. A row of MAX_TASKS identical slot cells holds each
// task's period and last-run time. A word with s_tuser = 0 registers a task in
// the next free slot and answers with one word (status registered plus slot id,
// or table full). A word with s_tuser = 1 runs a process pass: all cells
// compare (now - last run) against their period in the same cycle, then a token
// walks the chain one cell per cycle, held while a due word waits for m_tready,
// and every due slot sends one word (status due, slot id) in index order, the
// final one with m_tlast set; with nothing due a single "none due" word goes
// out. The length of a pass is set by the token walk up to the last due slot
// and by any stall while m_tready holds the output register. A new word is taken
// only between passes, while the output register is free or being drained. Slot
// ids are the low 4 bits of the slot index.
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_scheduler #(
    parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // [31:0] period, [63:32] now
    input  wire         s_tuser,   // [0] action
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [3:0] task_id, [7:4] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // last word of this request
);

`include "periodic_task_scheduler_defines.svh"

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic                            out_valid_reg, out_valid_next;
    logic [pts_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [pts_pkg::TASK_ID_W-1:0]   id_reg, id_next;
    logic                            last_reg, last_next;

    pts_pkg::cell_ctrl_t             ctrl;
    pts_pkg::cell_stat_t             stat [MAX_TASKS];
    logic [MAX_TASKS-1:0]            tok_q;
    logic [MAX_TASKS:0]              rest;
    logic                            launch;
    logic                            accept;
    logic                            out_free;
    logic                            full;
    logic                            hit_any;
    logic                            hit_last;
    logic [IDX_W-1:0]                hit_idx;

    assign rest[MAX_TASKS] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++)
        begin : g_cell
            pts_cell #(
                .CNT_W (CNT_W),
                .INDEX (g)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .count    (count_reg),
                .tok_in   ((g == 0) ? launch : tok_q[(g == 0) ? 0 : g - 1]),
                .tok_out  (tok_q[g]),
                .rest_in  (rest[g + 1]),
                .rest_out (rest[g]),
                .stat     (stat[g])
            );
        end
    endgenerate

    // Token is one-hot, so OR-ing the hit cells yields its index and flags.
    always_comb
    begin
        hit_any  = 1'b0;
        hit_last = 1'b0;
        hit_idx  = '0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if (stat[i].hit)
            begin
                hit_any  = 1'b1;
                hit_last = hit_last | stat[i].last;
                hit_idx  = hit_idx | IDX_W'(i);
            end
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(MAX_TASKS));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        status_next    = status_reg;
        id_next        = id_reg;
        last_next      = last_reg;
        launch         = 1'b0;
        ctrl.load      = 1'b0;
        ctrl.eval      = 1'b0;
        ctrl.advance   = 1'b0;
        ctrl.clear     = 1'b0;
        ctrl.period    = s_tdata[31:0];
        ctrl.now       = s_tdata[63:32];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == pts_pkg::ACT_PROCESS)
                    begin
                        ctrl.eval  = 1'b1;
                        state_next = S_CHECK;
                    end
                    else if (full)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = pts_pkg::ST_FULL;
                        id_next        = '0;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        ctrl.load      = 1'b1;
                        count_next     = count_reg + 1'b1;
                        out_valid_next = 1'b1;
                        status_next    = pts_pkg::ST_REGISTERED;
                        id_next        = pts_pkg::TASK_ID_W'(count_reg);
                        last_next      = 1'b1;
                    end
                end
            end

            S_CHECK:
            begin
                if (rest[0])
                begin
                    // inject the token into the first cell
                    launch       = 1'b1;
                    ctrl.advance = 1'b1;
                    state_next   = S_SCAN;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = pts_pkg::ST_NONE;
                    id_next        = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (!hit_any)
                begin
                    ctrl.advance = 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = pts_pkg::ST_DUE;
                    id_next        = pts_pkg::TASK_ID_W'(hit_idx);
                    last_next      = hit_last;
                    if (hit_last)
                    begin
                        ctrl.clear = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctrl.advance = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= pts_pkg::ST_REGISTERED;
            id_reg        <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            id_reg        <= id_next;
            last_reg      <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, id_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

    // Checks: single scan token, bounded table, token only during a scan,
    // and a successful register adds exactly one slot.
    `PTS_ASSERT_NOW(a_tok_onehot, 1'b1, $onehot0(tok_q), "more than one scan token")
    `PTS_ASSERT_NOW(a_count_max, 1'b1, count_reg <= CNT_W'(MAX_TASKS), "task count overflow")
    `PTS_ASSERT_NOW(a_tok_scan, tok_q != '0, state_reg == S_SCAN, "token outside scan")
    `PTS_ASSERT_NEXT(a_reg_inc, accept && (s_tuser == pts_pkg::ACT_REGISTER) && !full, count_reg == CNT_W'($past(count_reg) + 1'b1), "register did not add a slot")

endmodule

`default_nettype wire
